/* hdl/rti_pkg.sv */
package rti_pkg;

    // store geometry
    localparam int VERTEX_DEPTH = 1024;
    localparam int TRI_DEPTH    = 1024;

    // field widths
    localparam int IDX_W   = 10;
    localparam int CW      = 21;            // one Q10.10 coordinate
    localparam int XYZ_W   = 3 * CW;
    localparam int FACE_W  = 3 * IDX_W;
    localparam int EPS_W   = 21;
    localparam int T_W     = 32;
    localparam int BARY_W  = 17;
    localparam int ST_W    = 3;
    localparam int CMD_W   = 2;

    // datapath widths
    localparam int EW      = CW + 1;        // edge / offset component
    localparam int PRW     = 2 * EW;        // one cross product term
    localparam int PQW     = PRW + 1;       // cross product component
    localparam int LO_W    = 22;            // low half of a split operand
    localparam int DW      = 68;            // dot product
    localparam int CHUNK   = 23;            // det slice for the t range products
    localparam int MPW     = T_W + CHUNK + 1;
    localparam int XW      = 101;           // t numerator and scaled bounds
    localparam int T_FRAC  = 10;
    localparam int T_STEPS = T_W;           // quotient bits of t
    localparam int UV_STEPS = BARY_W;       // quotient bits of u and v
    localparam int RW      = DW + 1;        // u/v partial remainder

    // commands
    localparam logic [CMD_W-1:0] CMD_VERTEX = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FACE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ISECT  = 2'd2;

    typedef enum logic [ST_W-1:0] {
        ST_HIT      = 3'd0,
        ST_PARALLEL = 3'd1,
        ST_U_OUT    = 3'd2,
        ST_V_OUT    = 3'd3,
        ST_T_OUT    = 3'd4,
        ST_LOADED   = 3'd5
    } t_status;

    // control traveling down the pipe with each word
    typedef struct packed {
        logic                  vld;
        logic                  isect;
        logic signed [T_W-1:0] tmin;
        logic signed [T_W-1:0] tmax;
    } t_tag;

    typedef logic signed [EW-1:0] t_ecoord;

    typedef struct packed {
        t_ecoord [2:0] e1;
        t_ecoord [2:0] e2;
        t_ecoord [2:0] s;
        t_ecoord [2:0] d;
    } t_edges;

    function automatic logic signed [CW-1:0] coord(input logic [XYZ_W-1:0] xyz, input int k);
        return $signed(xyz[CW*k +: CW]);
    endfunction

endpackage

/* hdl/ray_triangle_intersect.sv */
// Channel  | Handshake           | Payload
// ---------+---------------------+-----------------------------------------
// in       | i_valid / o_stall   | cmd, vertex/tri index, vertex, face, ray, t range
// out      | o_valid / i_stall   | status, bary_u, bary_v, hit_t
// config   | i_cfg_we            | i_cfg_wdata -> det_epsilon
//
// One word accepted per cycle while o_stall is low. Results pass the face and
// vertex fetches, the geometry stages and the 32-stage t quotient pipe.
// Reset (synchronous, active low) clears only control; stores hold garbage
// until loaded. The whole pipe freezes only while a result is held under
// i_stall; o_stall follows that condition directly.
module ray_triangle_intersect import rti_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config
    input  logic                  i_cfg_we,
    input  logic [EPS_W-1:0]      i_cfg_wdata,
    // input channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [IDX_W-1:0]      i_vertex_index,
    input  logic [XYZ_W-1:0]      i_vertex_xyz,
    input  logic [IDX_W-1:0]      i_tri_index,
    input  logic [FACE_W-1:0]     i_face_corners,
    input  logic [XYZ_W-1:0]      i_ray_origin_xyz,
    input  logic [XYZ_W-1:0]      i_ray_dir_xyz,
    input  logic signed [T_W-1:0] i_t_min,
    input  logic signed [T_W-1:0] i_t_max,
    // output channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [ST_W-1:0]       o_status,
    output logic [BARY_W-1:0]     o_bary_u,
    output logic [BARY_W-1:0]     o_bary_v,
    output logic signed [T_W-1:0] o_hit_t
);

    localparam int VTX_AW = $clog2(VERTEX_DEPTH);
    localparam int TRI_AW = $clog2(TRI_DEPTH);

    logic               en, accept;
    logic               vtx_we, face_we;
    logic [EPS_W-1:0]   r_det_eps;

    // fetch stages: S1 has the face, S2 the three corners
    t_tag               n_tag, r_s1_tag, r_s2_tag;
    logic [XYZ_W-1:0]   r_s1_org, r_s1_dir, r_s2_org, r_s2_dir;
    logic               r_s1_fok;
    logic [FACE_W-1:0]  face_rd, face;
    logic [IDX_W-1:0]   corner [3];
    logic [2:0]         vok, r_s2_vok;
    logic [XYZ_W-1:0]   vtx_rd [3];
    logic [XYZ_W-1:0]   vtx [3];

    t_tag                 g_tag;
    logic signed [DW-1:0] g_det, g_nu, g_nv, g_nt;

    logic                  d_vld;
    t_status               d_status;
    logic [BARY_W-1:0]     d_u, d_v;
    logic signed [T_W-1:0] d_t;

    logic                  r_valid;
    t_status               r_status;
    logic [BARY_W-1:0]     r_u, r_v;
    logic signed [T_W-1:0] r_t;

    // pipe advances unless the held result is stalled
    assign en      = !r_valid || !i_stall;
    assign o_stall = !en;
    assign accept  = i_valid && en;

    // loads write at accept; writes past the store depth are dropped
    assign vtx_we  = accept && (i_cmd == CMD_VERTEX) && (32'(i_vertex_index) < VERTEX_DEPTH);
    assign face_we = accept && (i_cmd == CMD_FACE) && (32'(i_tri_index) < TRI_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_det_eps <= EPS_W'(11);
        end else if (i_cfg_we) begin
            r_det_eps <= i_cfg_wdata;
        end
    end

    always_comb begin
        n_tag.vld   = accept;
        n_tag.isect = (i_cmd == CMD_ISECT);
        n_tag.tmin  = i_t_min;
        n_tag.tmax  = i_t_max;
    end

    rti_ram #(.DEPTH(TRI_DEPTH), .WIDTH(FACE_W)) u_face_ram (
        .i_clk   (i_clk),
        .i_we    (face_we),
        .i_waddr (TRI_AW'(i_tri_index)),
        .i_wdata (i_face_corners),
        .i_re    (en),
        .i_raddr (TRI_AW'(i_tri_index)),
        .o_rdata (face_rd)
    );

    // out-of-range face reads as all zero: a degenerate triangle
    assign face = r_s1_fok ? face_rd : '0;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            corner[k] = face[IDX_W*k +: IDX_W];
            vok[k]    = 32'(corner[k]) < VERTEX_DEPTH;
        end
    end

    // one vertex copy per corner so all three are read in the same cycle
    for (genvar k = 0; k < 3; k++) begin : g_vtx
        rti_ram #(.DEPTH(VERTEX_DEPTH), .WIDTH(XYZ_W)) u_vtx_ram (
            .i_clk   (i_clk),
            .i_we    (vtx_we),
            .i_waddr (VTX_AW'(i_vertex_index)),
            .i_wdata (i_vertex_xyz),
            .i_re    (en),
            .i_raddr (VTX_AW'(corner[k])),
            .o_rdata (vtx_rd[k])
        );
        assign vtx[k] = r_s2_vok[k] ? vtx_rd[k] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_tag <= '0;
            r_s2_tag <= '0;
        end else if (en) begin
            r_s1_tag <= n_tag;
            r_s2_tag <= r_s1_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_org <= i_ray_origin_xyz;
            r_s1_dir <= i_ray_dir_xyz;
            r_s1_fok <= 32'(i_tri_index) < TRI_DEPTH;
            r_s2_org <= r_s1_org;
            r_s2_dir <= r_s1_dir;
            r_s2_vok <= vok;
        end
    end

    rti_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_tag   (r_s2_tag),
        .i_v0    (vtx[0]),
        .i_v1    (vtx[1]),
        .i_v2    (vtx[2]),
        .i_org   (r_s2_org),
        .i_dir   (r_s2_dir),
        .o_tag   (g_tag),
        .o_det   (g_det),
        .o_nu    (g_nu),
        .o_nv    (g_nv),
        .o_nt    (g_nt)
    );

    rti_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_eps    (r_det_eps),
        .i_tag    (g_tag),
        .i_det    (g_det),
        .i_nu     (g_nu),
        .i_nv     (g_nv),
        .i_nt     (g_nt),
        .o_vld    (d_vld),
        .o_status (d_status),
        .o_u      (d_u),
        .o_v      (d_v),
        .o_t      (d_t)
    );

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_status <= d_status;
            r_u      <= d_u;
            r_v      <= d_v;
            r_t      <= d_t;
        end
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_bary_u = r_u;
    assign o_bary_v = r_v;
    assign o_hit_t  = r_t;

endmodule

/* hdl/rti_ram.sv */
module rti_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 63,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first: a read and a write at the same edge return the old entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/rti_geom.sv */
module rti_geom import rti_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  t_tag                 i_tag,
    input  logic [XYZ_W-1:0]     i_v0,
    input  logic [XYZ_W-1:0]     i_v1,
    input  logic [XYZ_W-1:0]     i_v2,
    input  logic [XYZ_W-1:0]     i_org,
    input  logic [XYZ_W-1:0]     i_dir,
    output t_tag                 o_tag,
    output logic signed [DW-1:0] o_det,
    output logic signed [DW-1:0] o_nu,
    output logic signed [DW-1:0] o_nv,
    output logic signed [DW-1:0] o_nt
);

    localparam int STAGES = 7;

    t_tag r_tag [STAGES];

    t_edges n_ed, r1_ed, r2_ed, r3_ed;
    logic signed [PRW-1:0] n_pa [3], n_pb [3], n_qa [3], n_qb [3];
    logic signed [PRW-1:0] r_pa [3], r_pb [3], r_qa [3], r_qb [3];
    logic signed [PQW-1:0] n_p [3], n_q [3], r_p [3], r_q [3];
    logic signed [EW-1:0]  ma [4][3];
    logic signed [PQW-1:0] mb [4][3];
    logic signed [PQW-1:0] n_ph [4][3], n_pl [4][3], r_ph [4][3], r_pl [4][3];
    logic signed [DW-1:0]  n_pr [4][3], r_pr [4][3];
    logic signed [DW-1:0]  n_sm [4], r_sm [4], n_nm [4], r_nm [4];

    // edges, offset and direction
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_ed.e1[k] = EW'(coord(i_v1, k)) - EW'(coord(i_v0, k));
            n_ed.e2[k] = EW'(coord(i_v2, k)) - EW'(coord(i_v0, k));
            n_ed.s[k]  = EW'(coord(i_org, k)) - EW'(coord(i_v0, k));
            n_ed.d[k]  = EW'(coord(i_dir, k));
        end
    end

    // p = d x e2, q = s x e1: products, then differences
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_pa[k] = $signed(r1_ed.d[(k+1)%3]) * $signed(r1_ed.e2[(k+2)%3]);
            n_pb[k] = $signed(r1_ed.d[(k+2)%3]) * $signed(r1_ed.e2[(k+1)%3]);
            n_qa[k] = $signed(r1_ed.s[(k+1)%3]) * $signed(r1_ed.e1[(k+2)%3]);
            n_qb[k] = $signed(r1_ed.s[(k+2)%3]) * $signed(r1_ed.e1[(k+1)%3]);
            n_p[k]  = PQW'(r_pa[k]) - PQW'(r_pb[k]);
            n_q[k]  = PQW'(r_qa[k]) - PQW'(r_qb[k]);
        end
    end

    // dots: det = e1.p, nu = s.p, nv = d.q, nt = e2.q; wide operand split in two
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ma[0][k] = $signed(r3_ed.e1[k]);
            mb[0][k] = r_p[k];
            ma[1][k] = $signed(r3_ed.s[k]);
            mb[1][k] = r_p[k];
            ma[2][k] = $signed(r3_ed.d[k]);
            mb[2][k] = r_q[k];
            ma[3][k] = $signed(r3_ed.e2[k]);
            mb[3][k] = r_q[k];
        end
        for (int j = 0; j < 4; j++) begin
            for (int k = 0; k < 3; k++) begin
                n_ph[j][k] = ma[j][k] * $signed(mb[j][k][PQW-1:LO_W]);
                n_pl[j][k] = ma[j][k] * $signed({1'b0, mb[j][k][LO_W-1:0]});
                n_pr[j][k] = (DW'(r_ph[j][k]) <<< LO_W) + DW'(r_pl[j][k]);
            end
            n_sm[j] = r_pr[j][0] + r_pr[j][1] + r_pr[j][2];
            // make det non-negative, flip the numerators with it
            n_nm[j] = r_sm[0][DW-1] ? -r_sm[j] : r_sm[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STAGES; i++) begin
                r_tag[i] <= '0;
            end
        end else if (i_en) begin
            r_tag[0] <= i_tag;
            for (int i = 1; i < STAGES; i++) begin
                r_tag[i] <= r_tag[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ed <= n_ed;
            r2_ed <= r1_ed;
            r3_ed <= r2_ed;
            r_pa  <= n_pa;
            r_pb  <= n_pb;
            r_qa  <= n_qa;
            r_qb  <= n_qb;
            r_p   <= n_p;
            r_q   <= n_q;
            r_ph  <= n_ph;
            r_pl  <= n_pl;
            r_pr  <= n_pr;
            r_sm  <= n_sm;
            r_nm  <= n_nm;
        end
    end

    assign o_tag = r_tag[STAGES-1];
    assign o_det = r_nm[0];
    assign o_nu  = r_nm[1];
    assign o_nv  = r_nm[2];
    assign o_nt  = r_nm[3];

endmodule

/* hdl/rti_div.sv */
module rti_div import rti_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [EPS_W-1:0]     i_eps,
    input  t_tag                 i_tag,
    input  logic signed [DW-1:0] i_det,
    input  logic signed [DW-1:0] i_nu,
    input  logic signed [DW-1:0] i_nv,
    input  logic signed [DW-1:0] i_nt,
    output logic                 o_vld,
    output t_status              o_status,
    output logic [BARY_W-1:0]    o_u,
    output logic [BARY_W-1:0]    o_v,
    output logic signed [T_W-1:0] o_t
);

    localparam int N = T_STEPS;

    // range decisions and t-bound products
    logic                  n1_par, n1_uo, n1_vo;
    logic                  r1_par, r1_uo, r1_vo;
    logic signed [MPW-1:0] n1_mn [3], n1_mx [3], r1_mn [3], r1_mx [3];
    logic signed [DW-1:0]  r1_det, r1_nu, r1_nv, r1_nt;
    t_tag                  r1_tag;
    logic signed [CHUNK:0] dc [3];

    logic                  r2_par, r2_uo, r2_vo;
    logic signed [XW-1:0]  n2_tmind, n2_tmaxd, r2_tmind, r2_tmaxd, r2_nt10;
    logic signed [DW-1:0]  r2_det, r2_nu, r2_nv;
    t_tag                  r2_tag;

    logic                  t_lo, t_hi;
    t_status               n_st0;

    // divider stages
    t_tag               r_tag [N+1];
    t_status            r_st  [N+1];
    logic [DW-1:0]      r_det [N+1];
    logic [XW-1:0]      r_x   [N+1];
    logic [T_W-1:0]     r_qt  [N+1];
    logic [RW-1:0]      r_ru  [N+1];
    logic [RW-1:0]      r_rv  [N+1];
    logic [BARY_W-1:0]  r_qu  [N+1];
    logic [BARY_W-1:0]  r_qv  [N+1];

    logic hit;

    always_comb begin
        n1_par = (i_det == '0) || ($unsigned(i_det) < DW'(i_eps));
        n1_uo  = (i_nu < 0) || (i_nu > i_det);
        n1_vo  = (i_nv < 0) || ((RW'(i_nu) + RW'(i_nv)) > RW'(i_det));
        dc[0] = $signed({1'b0, i_det[CHUNK-1:0]});
        dc[1] = $signed({1'b0, i_det[2*CHUNK-1:CHUNK]});
        dc[2] = $signed({2'b00, i_det[DW-1:2*CHUNK]});
        for (int k = 0; k < 3; k++) begin
            n1_mn[k] = i_tag.tmin * dc[k];
            n1_mx[k] = i_tag.tmax * dc[k];
        end
        n2_tmind = XW'(r1_mn[0]) + (XW'(r1_mn[1]) <<< CHUNK) + (XW'(r1_mn[2]) <<< (2*CHUNK));
        n2_tmaxd = XW'(r1_mx[0]) + (XW'(r1_mx[1]) <<< CHUNK) + (XW'(r1_mx[2]) <<< (2*CHUNK));
    end

    // t outside exactly when nt*2^10 leaves [tmin*det, tmax*det]
    always_comb begin
        t_lo = r2_nt10 < r2_tmind;
        t_hi = r2_nt10 > r2_tmaxd;
        if (!r2_tag.isect) begin
            n_st0 = ST_LOADED;
        end else if (r2_par) begin
            n_st0 = ST_PARALLEL;
        end else if (r2_uo) begin
            n_st0 = ST_U_OUT;
        end else if (r2_vo) begin
            n_st0 = ST_V_OUT;
        end else if (t_lo || t_hi) begin
            n_st0 = ST_T_OUT;
        end else begin
            n_st0 = ST_HIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_tag   <= '0;
            r2_tag   <= '0;
            r_tag[0] <= '0;
        end else if (i_en) begin
            r1_tag   <= i_tag;
            r2_tag   <= r1_tag;
            r_tag[0] <= r2_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_par   <= n1_par;
            r1_uo    <= n1_uo;
            r1_vo    <= n1_vo;
            r1_mn    <= n1_mn;
            r1_mx    <= n1_mx;
            r1_det   <= i_det;
            r1_nu    <= i_nu;
            r1_nv    <= i_nv;
            r1_nt    <= i_nt;
            r2_par   <= r1_par;
            r2_uo    <= r1_uo;
            r2_vo    <= r1_vo;
            r2_tmind <= n2_tmind;
            r2_tmaxd <= n2_tmaxd;
            r2_nt10  <= XW'(r1_nt) <<< T_FRAC;
            r2_det   <= r1_det;
            r2_nu    <= r1_nu;
            r2_nv    <= r1_nv;
            r_st[0]  <= n_st0;
            r_det[0] <= $unsigned(r2_det);
            r_x[0]   <= $unsigned(r2_nt10 - r2_tmind);
            r_qt[0]  <= '0;
            r_ru[0]  <= RW'($unsigned(r2_nu));
            r_rv[0]  <= RW'($unsigned(r2_nv));
            r_qu[0]  <= '0;
            r_qv[0]  <= '0;
        end
    end

    // one quotient bit of t per stage; u and v share the first stages
    for (genvar j = 0; j < N; j++) begin : g_step
        logic [XW-1:0]     ds;
        logic              t_ge;
        logic [RW-1:0]     ru_s, rv_s, dr;
        logic              u_ge, v_ge;
        logic [RW-1:0]     n_ru, n_rv;
        logic [BARY_W-1:0] n_qu, n_qv;

        always_comb begin
            ds   = XW'(r_det[j]) << (N - 1 - j);
            t_ge = r_x[j] >= ds;
            dr   = RW'(r_det[j]);
            ru_s = (j == 0) ? r_ru[j] : (r_ru[j] << 1);
            rv_s = (j == 0) ? r_rv[j] : (r_rv[j] << 1);
            u_ge = ru_s >= dr;
            v_ge = rv_s >= dr;
            if (j < UV_STEPS) begin
                n_ru = u_ge ? ru_s - dr : ru_s;
                n_rv = v_ge ? rv_s - dr : rv_s;
                n_qu = {r_qu[j][BARY_W-2:0], u_ge};
                n_qv = {r_qv[j][BARY_W-2:0], v_ge};
            end else begin
                n_ru = r_ru[j];
                n_rv = r_rv[j];
                n_qu = r_qu[j];
                n_qv = r_qv[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[j+1] <= '0;
            end else if (i_en) begin
                r_tag[j+1] <= r_tag[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[j+1]  <= r_st[j];
                r_det[j+1] <= r_det[j];
                r_x[j+1]   <= t_ge ? r_x[j] - ds : r_x[j];
                r_qt[j+1]  <= {r_qt[j][T_W-2:0], t_ge};
                r_ru[j+1]  <= n_ru;
                r_rv[j+1]  <= n_rv;
                r_qu[j+1]  <= n_qu;
                r_qv[j+1]  <= n_qv;
            end
        end
    end

    assign hit      = (r_st[N] == ST_HIT);
    assign o_vld    = r_tag[N].vld;
    assign o_status = r_st[N];
    assign o_u      = hit ? r_qu[N] : '0;
    assign o_v      = hit ? r_qv[N] : '0;
    assign o_t      = hit ? r_tag[N].tmin + $signed(r_qt[N]) : '0;

endmodule

/* hdl/rti_checker.sv */
module rti_checker import rti_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_stall,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [ST_W-1:0]       o_status,
    input logic [BARY_W-1:0]     o_bary_u,
    input logic [BARY_W-1:0]     o_bary_v,
    input logic signed [T_W-1:0] o_hit_t
);

    // held word keeps its status and t
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_hit_t))
        else $error("output word changed under stall");

    // input stalls only behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without held output");

    // misses and loads carry zero payload
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_HIT) |->
            (o_bary_u == '0) && (o_bary_v == '0) && (o_hit_t == '0))
        else $error("nonzero payload on a miss");

    // barycentrics of a hit stay inside the triangle
    a_bary_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_HIT) |->
            (({1'b0, o_bary_u} + {1'b0, o_bary_v}) <= 18'd65536))
        else $error("u + v above one on a hit");

endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (.*);
